@@ rtl/thuf_pkg.sv @@
// Package: sample format codes, float constants and the byte-to-unit lookup table.
package thuf_pkg;

  localparam logic [1:0] FMT_U8     = 2'd0;
  localparam logic [1:0] FMT_HALF   = 2'd1;
  localparam logic [1:0] FMT_SINGLE = 2'd2;
  localparam logic [1:0] FMT_NONE   = 2'd3;

  localparam logic [31:0] SIGN_BIT32  = 32'h8000_0000;
  localparam logic [31:0] EXP_MASK32  = 32'h7F80_0000;
  localparam logic [31:0] MANT_MASK32 = 32'h007F_FFFF;
  localparam logic [31:0] ONE_BITS    = 32'h3F80_0000;
  localparam logic [7:0]  HALF_BIAS_ADJ = 8'd112;

  typedef logic [31:0] byte_lut_t [256];

  // Build v/255 as a correctly rounded single for every byte value.
  function automatic byte_lut_t build_byte_lut();
    byte_lut_t lut;
    longint    num;
    longint    q;
    longint    r;
    int        s;
    int        sh;
    int        ex;
    lut[0] = 32'h0;
    for (int v = 1; v < 256; v++) begin
      sh = 0;
      for (s = 0; s < 40; s++) begin
        num = longint'(v) << s;
        if ((num / 255) >= (64'd1 << 23) && sh == 0) sh = s;
      end
      num = longint'(v) << sh;
      q = num / 255;
      r = num % 255;
      if (2 * r > 255) q = q + 1;
      ex = 150 - sh;
      if (q == (64'd1 << 24)) begin
        q  = q >> 1;
        ex = ex + 1;
      end
      lut[v] = {1'b0, 8'(ex), 23'(q)};
    end
    return lut;
  endfunction

  localparam byte_lut_t BYTE_LUT = build_byte_lut();

endpackage

@@ rtl/texel_height_to_unit_float.sv @@
// Top level: height sample to clamped single-precision float, two register stages.
//
// Usage:
//   The input channel (in_valid, in_stall) carries one raw sample word and a
//   last-pixel mark. The result channel (out_valid, out_stall) carries the
//   clamped height bits, the unsupported flag and the last mark.
//   The cfg channel (cfg_valid, cfg_ready) writes the 2-bit sample format;
//   cfg_ready is high only while no word is held inside the block.
//   Path: a word accepted enters the input register, passes the conversion
//   logic and is then registered in the result register that drives out_*.
//   Throughput: one word per cycle while out_stall is low; the input register
//   and the result register form a two-deep pipeline, and the conversion logic
//   sits between them (byte lookup table, half widening, clamp compare).
//   Reset: both stages empty, format returns to unsigned 8-bit.
//   Stall: when out_stall holds a valid result, the input register keeps its
//   word and in_stall rises once that register is full.
module texel_height_to_unit_float
  import thuf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_raw_sample,
  input  logic        in_last_pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_height_bits,
  output logic        out_unsupported,
  output logic        out_last_height,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_sample_format
);

  logic [1:0]  fmt_r;
  logic        s1_valid_r;
  logic [31:0] s1_raw_r;
  logic        s1_last_r;
  logic        out_valid_r;
  logic [31:0] out_height_r;
  logic        out_bad_r;
  logic        out_last_r;

  logic        adv_out;
  logic        adv_in;
  logic [31:0] byte_bits;
  logic [31:0] half_bits;
  logic [31:0] pre_bits;
  logic [31:0] height_nxt;
  logic        bad_nxt;
  logic        is_nan;
  logic [4:0]  h_ex;
  logic [9:0]  h_man;
  logic [3:0]  lead;
  logic [9:0]  sub_man;
  logic [7:0]  sub_ex;

  assign adv_out   = !out_valid_r || !out_stall;
  assign adv_in    = !s1_valid_r || adv_out;
  assign in_stall  = !adv_in;
  assign cfg_ready = !s1_valid_r && !out_valid_r;

  assign out_valid       = out_valid_r;
  assign out_height_bits = out_height_r;
  assign out_unsupported = out_bad_r;
  assign out_last_height = out_last_r;

  assign byte_bits = BYTE_LUT[s1_raw_r[7:0]];

  assign h_ex  = s1_raw_r[14:10];
  assign h_man = s1_raw_r[9:0];

  // Find the leading one of a subnormal mantissa.
  always_comb begin
    lead = 4'd0;
    for (int p = 0; p < 10; p++) begin
      if (h_man[p]) lead = 4'(p);
    end
    sub_man = 10'(h_man << (4'd10 - lead));
    sub_ex  = 8'(lead) + 8'd103;
  end

  always_comb begin
    if (h_ex == 5'd0) begin
      if (h_man == 10'd0) half_bits = {s1_raw_r[15], 31'd0};
      else                half_bits = {s1_raw_r[15], sub_ex, sub_man, 13'd0};
    end else if (h_ex == 5'h1F) begin
      half_bits = {s1_raw_r[15], 8'hFF, h_man, 13'd0};
    end else begin
      half_bits = {s1_raw_r[15], 8'(h_ex) + HALF_BIAS_ADJ, h_man, 13'd0};
    end
  end

  always_comb begin
    bad_nxt = 1'b0;
    unique case (fmt_r)
      FMT_U8:     pre_bits = byte_bits;
      FMT_HALF:   pre_bits = half_bits;
      FMT_SINGLE: pre_bits = s1_raw_r;
      default: begin
        pre_bits = 32'd0;
        bad_nxt  = 1'b1;
      end
    endcase
    is_nan = ((pre_bits & EXP_MASK32) == EXP_MASK32) && ((pre_bits & MANT_MASK32) != 32'd0);
    // Keep NaN and negative zero, drop negatives to zero, cap at one.
    priority if (is_nan)                height_nxt = pre_bits;
    else if (pre_bits == SIGN_BIT32)    height_nxt = pre_bits;
    else if (pre_bits[31])              height_nxt = 32'd0;
    else if (pre_bits > ONE_BITS)       height_nxt = ONE_BITS;
    else                                height_nxt = pre_bits;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= FMT_U8;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) fmt_r <= cfg_sample_format;
      if (adv_in) s1_valid_r <= in_valid;
      if (adv_out) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && in_valid) begin
      s1_raw_r  <= in_raw_sample;
      s1_last_r <= in_last_pixel;
    end
    if (adv_out && s1_valid_r) begin
      out_height_r <= height_nxt;
      out_bad_r    <= bad_nxt;
      out_last_r   <= s1_last_r;
    end
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> out_height_r == 32'd0)
    else $error("unsupported result with nonzero height");

  a_no_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_height_r[31] && out_height_r[30:23] != 8'hFF
      |-> out_height_r == SIGN_BIT32)
    else $error("negative height escaped clamp");

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_height_r[31] && out_height_r[30:23] != 8'hFF
      |-> out_height_r <= ONE_BITS)
    else $error("height above one");

  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid_r && !in_stall)
    else $error("pipeline not empty after reset");

endmodule
